### rtl/uss_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer package
// Shared constants and the job type passed from the classifier to the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uss_pkg;

  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead2Max   = 8'hDF;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead3Max   = 8'hEF;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Lead4Max   = 8'hF4;
  localparam logic [7:0] ContMin    = 8'h80;
  localparam logic [7:0] ContMax    = 8'hBF;
  localparam logic [7:0] SpaceByte  = 8'h20;

  localparam int unsigned HoldDepth    = 3;
  localparam int unsigned JobBytes     = 4;
  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    logic [2:0]               cnt;
  } uss_job_t;

endpackage

### rtl/uss_front.sv
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer classifier
// Accepts one byte per cycle while accept_i is high, tracks the open sequence
// and builds a job that lists every output byte the input byte causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uss_front import uss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic [7:0] byte_in_i,
  input  logic     text_end_i,
  output logic     job_valid_o,
  output uss_job_t job_o
);

  logic [HoldDepth-1:0][7:0] held_q, held_d;
  logic [1:0] count_q, count_d;
  logic [2:0] need_q, need_d;

  always_comb begin
    logic [2:0] n;
    logic       is_cont;
    logic       fresh;
    n       = 3'd0;
    job_o   = '0;
    held_d  = held_q;
    count_d = count_q;
    need_d  = need_q;
    is_cont = (byte_in_i >= ContMin) && (byte_in_i <= ContMax);
    fresh   = 1'b0;

    if (need_q != 3'd0 && count_q != 2'd0) begin
      if (is_cont) begin
        if ({1'b0, count_q} + 3'd1 >= need_q) begin
          if (count_q >= 2'd1) begin
            job_o.bytes[n[1:0]] = held_q[0];
            n = n + 3'd1;
          end
          if (count_q >= 2'd2) begin
            job_o.bytes[n[1:0]] = held_q[1];
            n = n + 3'd1;
          end
          if (count_q == 2'd3) begin
            job_o.bytes[n[1:0]] = held_q[2];
            n = n + 3'd1;
          end
          job_o.bytes[n[1:0]] = byte_in_i;
          n = n + 3'd1;
          count_d = 2'd0;
          need_d  = 3'd0;
        end else if (count_q == 2'd1) begin
          held_d[1] = byte_in_i;
          count_d   = 2'd2;
        end else if (count_q == 2'd2) begin
          held_d[2] = byte_in_i;
          count_d   = 2'd3;
        end else begin
          if (count_q >= 2'd2) begin
            job_o.bytes[n[1:0]] = SpaceByte;
            n = n + 3'd1;
          end
          if (count_q == 2'd3) begin
            job_o.bytes[n[1:0]] = SpaceByte;
            n = n + 3'd1;
          end
          count_d = 2'd0;
          need_d  = 3'd0;
        end
      end else begin
        if (count_q >= 2'd2) begin
          job_o.bytes[n[1:0]] = SpaceByte;
          n = n + 3'd1;
        end
        if (count_q == 2'd3) begin
          job_o.bytes[n[1:0]] = SpaceByte;
          n = n + 3'd1;
        end
        count_d = 2'd0;
        need_d  = 3'd0;
        fresh   = 1'b1;
      end
    end else begin
      count_d = 2'd0;
      need_d  = 3'd0;
      fresh   = 1'b1;
    end

    if (fresh) begin
      if (byte_in_i <= AsciiMax) begin
        job_o.bytes[n[1:0]] = byte_in_i;
        n = n + 3'd1;
      end else if (byte_in_i >= Lead2Min && byte_in_i <= Lead2Max) begin
        held_d[0] = byte_in_i;
        count_d   = 2'd1;
        need_d    = 3'd2;
      end else if (byte_in_i >= Lead3Min && byte_in_i <= Lead3Max) begin
        held_d[0] = byte_in_i;
        count_d   = 2'd1;
        need_d    = 3'd3;
      end else if (byte_in_i >= Lead4Min && byte_in_i <= Lead4Max) begin
        held_d[0] = byte_in_i;
        count_d   = 2'd1;
        need_d    = 3'd4;
      end else begin
        job_o.bytes[n[1:0]] = SpaceByte;
        n = n + 3'd1;
      end
    end

    if (text_end_i && need_d != 3'd0) begin
      if (count_d >= 2'd2) begin
        job_o.bytes[n[1:0]] = SpaceByte;
        n = n + 3'd1;
      end
      if (count_d == 2'd3) begin
        job_o.bytes[n[1:0]] = SpaceByte;
        n = n + 3'd1;
      end
      count_d = 2'd0;
      need_d  = 3'd0;
    end

    job_o.cnt   = n;
    job_valid_o = accept_i && (n != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      need_q  <= 3'd0;
    end else if (accept_i) begin
      count_q <= count_d;
      need_q  <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

### rtl/uss_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer job queue
// A small register queue of jobs between the classifier and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uss_queue import uss_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  uss_job_t wr_job_i,
  input  logic     rd_i,
  output uss_job_t rd_job_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  uss_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o   = (cnt_q == FullCnt);
  assign empty_o  = (cnt_q == '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

### rtl/uss_back.sv
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer emitter
// Walks through the bytes of the job at the head of the queue, one per pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uss_back import uss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  uss_job_t   job_i,
  input  logic       job_empty_i,
  output logic       job_done_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] byte_out_o,
  output logic       run_last_o
);

  logic [1:0] idx_q;
  logic       fire;

  assign empty_o    = job_empty_i;
  assign fire       = pop_i && !job_empty_i;
  assign byte_out_o = job_i.bytes[idx_q];
  assign run_last_o = ({1'b0, idx_q} + 3'd1 == job_i.cnt);
  assign job_done_o = fire && run_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= run_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

### rtl/utf8_stream_sanitizer.sv
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer
// Passes valid UTF-8 sequences, turns stray bytes into spaces and drops the
// lead of a broken sequence.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  --------+-------------------------------+---------------------------
//  input   | byte_in_i, text_end_i         | push / full
//  result  | byte_out_o, run_last_o        | empty / pop
//
// One byte is accepted per cycle while the job queue has room. A byte causes
// zero to four results, and the emitter delivers one result per cycle while
// pop is asserted, so a completed multi-byte sequence takes one pop per byte.
// Each job is registered in the job queue before its results appear.
// Reset clears the open sequence, the queue and the emitter position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_sanitizer import uss_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_in_i,
  input  logic       text_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] byte_out_o,
  output logic       run_last_o
);

  logic     accept;
  logic     job_valid;
  uss_job_t job_new;
  uss_job_t job_head;
  logic     q_empty;
  logic     job_done;

  assign accept = push && !full;

  uss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_in_i   (byte_in_i),
    .text_end_i  (text_end_i),
    .job_valid_o (job_valid),
    .job_o       (job_new)
  );

  uss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_valid),
    .wr_job_i (job_new),
    .rd_i     (job_done),
    .rd_job_o (job_head),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  uss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (q_empty),
    .job_done_o  (job_done),
    .pop_i       (pop),
    .empty_o     (empty),
    .byte_out_o  (byte_out_o),
    .run_last_o  (run_last_o)
  );

endmodule

### rtl/uss_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer checker
// Port-level checks on the sanitizer, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [7:0] byte_in_i,
  input logic       text_end_i,
  input logic       empty,
  input logic       pop,
  input logic [7:0] byte_out_o,
  input logic       run_last_o
);

  a_held_item_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(byte_out_o) && $stable(run_last_o)))
    else $error("waiting result item changed");

  a_ascii_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && byte_in_i <= 8'h7F) |=> !empty)
    else $error("ASCII item produced no result");

  a_no_bad_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(byte_out_o == 8'hC0 || byte_out_o == 8'hC1 || byte_out_o >= 8'hF5))
    else $error("invalid UTF-8 byte on output");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("full and empty at once");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (empty && !full))
    else $error("results present after reset");

endmodule

bind utf8_stream_sanitizer uss_checker u_uss_checker (.*);
